>>> rtl/small_cpu_instruction_step_macros.svh
// Assertion macros for the small CPU instruction step block.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef SMALL_CPU_INSTRUCTION_STEP_MACROS_SVH
`define SMALL_CPU_INSTRUCTION_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define SCIS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scis: assertion failed");
`define SCIS_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("scis: forbidden condition");
`else
`define SCIS_ASSERT(lbl, prop)
`define SCIS_ASSERT_NEVER(lbl, expr)
`endif
`endif

>>> rtl/scis_pkg.sv
// Shared types, opcodes and controller/datapath command and status structs.
// No dependencies.
package scis_pkg;

    localparam int MEM_BYTES_DEF = 256;

    typedef struct packed {
        logic        kind;
        logic [7:0]  load_address;
        logic [31:0] load_word;
        logic [3:0]  peek_register;
    } in_t;

    typedef struct packed {
        logic [7:0]  program_counter_out;
        logic        halted_out;
        logic        equal_flag_out;
        logic        less_flag_out;
        logic        greater_flag_out;
        logic [4:0]  opcode_out;
        logic [31:0] peek_value;
    } out_t;

    typedef enum logic [4:0] {
        OP_HLT   = 5'd0,
        OP_NOP   = 5'd1,
        OP_NOT   = 5'd2,
        OP_MOVR  = 5'd3,
        OP_CMP   = 5'd4,
        OP_LDBO  = 5'd5,
        OP_STBO  = 5'd6,
        OP_ADD   = 5'd7,
        OP_SUB   = 5'd8,
        OP_MUL   = 5'd9,
        OP_UDIV  = 5'd10,
        OP_AND   = 5'd11,
        OP_OR    = 5'd12,
        OP_XOR   = 5'd13,
        OP_LD    = 5'd14,
        OP_ST    = 5'd15,
        OP_MOVIL = 5'd16,
        OP_MOVIH = 5'd17,
        OP_ADDI  = 5'd18,
        OP_SUBI  = 5'd19,
        OP_MULI  = 5'd20,
        OP_UDIVI = 5'd21,
        OP_SHL   = 5'd22,
        OP_SHR   = 5'd23,
        OP_JE    = 5'd24,
        OP_JNE   = 5'd25,
        OP_JL    = 5'd26,
        OP_JLE   = 5'd27,
        OP_JG    = 5'd28,
        OP_JGE   = 5'd29,
        OP_JMP   = 5'd30,
        OP_RSV   = 5'd31
    } op_e;

    typedef enum logic [1:0] {RS_X, RS_Y, RS_Z, RS_PEEK} rsel_e;
    typedef enum logic [1:0] {CAP_NONE, CAP_A, CAP_B, CAP_C} cap_e;
    typedef enum logic [1:0] {WS_RES, WS_QUOT, WS_BUF} wsrc_e;
    typedef enum logic [1:0] {DS_LDADDR, DS_ADDR, DS_RR, DS_RI} div_src_e;

    typedef struct packed {
        logic     clr;
        logic     latch_item;
        logic     mem_rd;
        logic     mem_wr;
        logic     shift_in;
        logic     k_clr;
        logic     k_inc;
        rsel_e    rf_rsel;
        cap_e     cap;
        logic     div_start;
        div_src_e div_src;
        logic     base_from_pc;
        logic     base_from_addr;
        logic     load_ir;
        logic     alu_exec;
        logic     rf_wr;
        wsrc_e    wsrc;
        logic     pc_adv;
        logic     pc_jump;
        logic     set_flags;
        logic     set_halt;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic kind;
        logic halted;
        logic k_last;
        logic div_busy;
        op_e  opcode;
        logic jump_taken;
    } stat_t;

endpackage

>>> rtl/scis_div.sv
// Iterative restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on nothing; a zero divisor yields an all-ones quotient.
module scis_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quot
);
    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] shifted;
    logic [32:0] trial;

    assign shifted = {r_reg, q_reg[31]};
    assign trial   = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= 32'd0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[31:0];
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
endmodule

>>> rtl/scis_dp.sv
// Datapath: byte memory, register file, fetch buffer, ALU, flags and program counter.
// Depends on scis_pkg and scis_div; driven by scis_ctrl commands.
module scis_dp #(
    parameter int MEM_BYTES = scis_pkg::MEM_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  scis_pkg::in_t  item,
    input  scis_pkg::cmd_t cmd,
    output scis_pkg::stat_t st,
    output scis_pkg::out_t result
);
    import scis_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW:0] MEM_N = (AW+1)'(MEM_BYTES);

    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    mem_rdata_reg;
    logic [31:0]   rf [16];
    logic [31:0]   rf_rdata_reg;
    in_t           item_reg;
    logic [31:0]   ir_reg;
    logic [31:0]   a_reg;
    logic [31:0]   b_reg;
    logic [31:0]   c_reg;
    logic [31:0]   buf_reg;
    logic [31:0]   res_reg;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] pc_reg;
    logic [AW-1:0] clr_reg;
    logic [1:0]    k_reg;
    logic          eq_reg;
    logic          lt_reg;
    logic          gt_reg;
    logic          halted_reg;
    logic          ran_reg;

    op_e           op;
    logic [3:0]    rx;
    logic [3:0]    ry;
    logic [3:0]    rz;
    logic [31:0]   i23;
    logic [15:0]   i16;

    logic [AW:0]   bsum;
    logic [AW:0]   bsum_wrap;
    logic [AW-1:0] mem_addr;
    logic [31:0]   wword;
    logic [7:0]    mem_wdata;
    logic [AW:0]   psum;
    logic [AW:0]   psum_wrap;
    logic [31:0]   pc_wide;

    logic [3:0]    rf_raddr;
    logic [3:0]    rf_waddr;
    logic          rf_we;
    logic [31:0]   rf_wdata;

    logic [31:0]   opnd1;
    logic [31:0]   opnd2;
    logic [31:0]   alu_val;

    logic [31:0]   addr_val;
    logic [31:0]   div_dividend;
    logic [31:0]   div_divisor;
    logic          div_busy;
    logic [31:0]   div_quot;
    logic          jump_taken;

    assign op  = op_e'(ir_reg[31:27]);
    assign rx  = ir_reg[26:23];
    assign ry  = ir_reg[22:19];
    assign rz  = ir_reg[18:15];
    assign i23 = {9'd0, ir_reg[22:0]};
    assign i16 = ir_reg[15:0];

    assign bsum      = {1'b0, base_reg} + (AW+1)'(k_reg);
    assign bsum_wrap = bsum - MEM_N;
    assign mem_addr  = cmd.clr ? clr_reg
                     : (bsum >= MEM_N ? bsum_wrap[AW-1:0] : bsum[AW-1:0]);
    assign wword     = item_reg.kind ? a_reg : item_reg.load_word;
    assign mem_wdata = cmd.clr ? 8'd0 : wword[{~k_reg, 3'b000} +: 8];

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr || cmd.clr)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        case (cmd.rf_rsel)
            RS_X:    rf_raddr = rx;
            RS_Y:    rf_raddr = ry;
            RS_Z:    rf_raddr = rz;
            RS_PEEK: rf_raddr = item_reg.peek_register;
            default: rf_raddr = rx;
        endcase
        case (cmd.wsrc)
            WS_RES:  rf_wdata = res_reg;
            WS_QUOT: rf_wdata = div_quot;
            WS_BUF:  rf_wdata = buf_reg;
            default: rf_wdata = res_reg;
        endcase
        if (cmd.clr)
        begin
            rf_wdata = 32'd0;
        end
    end

    assign rf_waddr = cmd.clr ? clr_reg[3:0] : rx;
    assign rf_we    = cmd.rf_wr || (cmd.clr && (32'(clr_reg) < 32'd16));

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf[rf_waddr] <= rf_wdata;
        end
        rf_rdata_reg <= rf[rf_raddr];
    end

    always_comb
    begin
        if (op >= OP_ADDI)
        begin
            opnd1 = a_reg;
            opnd2 = i23;
        end
        else
        begin
            opnd1 = b_reg;
            opnd2 = c_reg;
        end
        case (op)
            OP_NOT:           alu_val = (a_reg == 32'd0) ? 32'd1 : 32'd0;
            OP_MOVR:          alu_val = b_reg;
            OP_ADD, OP_ADDI:  alu_val = opnd1 + opnd2;
            OP_SUB, OP_SUBI:  alu_val = opnd1 - opnd2;
            OP_MUL, OP_MULI:  alu_val = opnd1 * opnd2;
            OP_AND:           alu_val = b_reg & c_reg;
            OP_OR:            alu_val = b_reg | c_reg;
            OP_XOR:           alu_val = b_reg ^ c_reg;
            OP_MOVIL:         alu_val = {16'd0, i16};
            OP_MOVIH:         alu_val = {i16, a_reg[15:0]};
            OP_SHL:           alu_val = (ir_reg[22:5] != 18'd0) ? 32'd0 : (a_reg << ir_reg[4:0]);
            OP_SHR:           alu_val = (ir_reg[22:5] != 18'd0) ? 32'd0 : (a_reg >> ir_reg[4:0]);
            default:          alu_val = a_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.div_src)
            DS_LDADDR: addr_val = {24'd0, item_reg.load_address};
            DS_ADDR:   addr_val = i23 + (((op == OP_LDBO) || (op == OP_STBO)) ? b_reg : 32'd0);
            default:   addr_val = i23;
        endcase
        case (cmd.div_src)
            DS_RI:
            begin
                div_dividend = a_reg;
                div_divisor  = i23;
            end
            default:
            begin
                div_dividend = b_reg;
                div_divisor  = c_reg;
            end
        endcase
    end

    scis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    always_comb
    begin
        case (op)
            OP_JE:   jump_taken = eq_reg;
            OP_JNE:  jump_taken = !eq_reg;
            OP_JL:   jump_taken = lt_reg;
            OP_JLE:  jump_taken = eq_reg || lt_reg;
            OP_JG:   jump_taken = gt_reg;
            OP_JGE:  jump_taken = eq_reg || gt_reg;
            OP_JMP:  jump_taken = 1'b1;
            default: jump_taken = 1'b0;
        endcase
    end

    assign psum      = {1'b0, pc_reg} + (AW+1)'(4);
    assign psum_wrap = psum - MEM_N;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            clr_reg    <= '0;
            eq_reg     <= 1'b0;
            lt_reg     <= 1'b0;
            gt_reg     <= 1'b0;
            halted_reg <= 1'b0;
            ran_reg    <= 1'b0;
            k_reg      <= 2'd0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.pc_adv)
            begin
                pc_reg <= (psum >= MEM_N) ? psum_wrap[AW-1:0] : psum[AW-1:0];
            end
            else if (cmd.pc_jump)
            begin
                pc_reg <= i23[AW-1:0];
            end
            if (cmd.set_flags)
            begin
                eq_reg <= (a_reg == b_reg);
                lt_reg <= (a_reg < b_reg);
                gt_reg <= (a_reg > b_reg);
            end
            if (cmd.set_halt)
            begin
                halted_reg <= 1'b1;
            end
            if (cmd.latch_item)
            begin
                ran_reg <= 1'b0;
            end
            else if (cmd.load_ir)
            begin
                ran_reg <= 1'b1;
            end
            if (cmd.k_clr)
            begin
                k_reg <= 2'd0;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= item;
        end
        if (cmd.shift_in)
        begin
            buf_reg <= {buf_reg[23:0], mem_rdata_reg};
        end
        if (cmd.load_ir)
        begin
            ir_reg <= buf_reg;
        end
        if (cmd.base_from_pc)
        begin
            base_reg <= pc_reg;
        end
        else if (cmd.base_from_addr)
        begin
            base_reg <= addr_val[AW-1:0];
        end
        if (cmd.alu_exec)
        begin
            res_reg <= alu_val;
        end
        case (cmd.cap)
            CAP_A:   a_reg <= rf_rdata_reg;
            CAP_B:   b_reg <= rf_rdata_reg;
            CAP_C:   c_reg <= rf_rdata_reg;
            default: ;
        endcase
    end

    assign st.clr_done   = (clr_reg == AW'(MEM_BYTES - 1));
    assign st.kind       = item_reg.kind;
    assign st.halted     = halted_reg;
    assign st.k_last     = (k_reg == 2'd3);
    assign st.div_busy   = div_busy;
    assign st.opcode     = op;
    assign st.jump_taken = jump_taken;

    assign pc_wide = 32'(pc_reg);

    assign result.program_counter_out = pc_wide[7:0];
    assign result.halted_out          = halted_reg;
    assign result.equal_flag_out      = eq_reg;
    assign result.less_flag_out       = lt_reg;
    assign result.greater_flag_out    = gt_reg;
    assign result.opcode_out          = ran_reg ? ir_reg[31:27] : 5'd0;
    assign result.peek_value          = rf_rdata_reg;
endmodule

>>> rtl/scis_ctrl.sv
// Sequencer state machine: clearing pass, fetch, operand reads, execute and report.
// Depends on scis_pkg and the assertion macro header.
`include "small_cpu_instruction_step_macros.svh"
module scis_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  scis_pkg::stat_t st,
    output scis_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);
    import scis_pkg::*;

    typedef enum logic [19:0] {
        S_CLEAR = 20'd1 << 0,
        S_IDLE  = 20'd1 << 1,
        S_DISP  = 20'd1 << 2,
        S_FRD   = 20'd1 << 3,
        S_FCAP  = 20'd1 << 4,
        S_FDONE = 20'd1 << 5,
        S_RX    = 20'd1 << 6,
        S_RY    = 20'd1 << 7,
        S_RZ    = 20'd1 << 8,
        S_DEC   = 20'd1 << 9,
        S_OPS   = 20'd1 << 10,
        S_ALU   = 20'd1 << 11,
        S_WB    = 20'd1 << 12,
        S_UDIV  = 20'd1 << 13,
        S_MWR   = 20'd1 << 14,
        S_LRD   = 20'd1 << 15,
        S_LCAP  = 20'd1 << 16,
        S_LWB   = 20'd1 << 17,
        S_PEEK  = 20'd1 << 18,
        S_OUT   = 20'd1 << 19
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_store;

    assign is_store = (st.opcode == OP_STBO) || (st.opcode == OP_ST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.k_clr = 1'b1;
                if (!st.kind)
                begin
                    cmd.div_src        = DS_LDADDR;
                    cmd.base_from_addr = 1'b1;
                    state_next         = S_MWR;
                end
                else if (st.halted)
                begin
                    state_next = S_PEEK;
                end
                else
                begin
                    cmd.base_from_pc = 1'b1;
                    state_next       = S_FRD;
                end
            end
            S_FRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_FCAP;
            end
            S_FCAP:
            begin
                cmd.shift_in = 1'b1;
                cmd.k_inc    = 1'b1;
                state_next   = st.k_last ? S_FDONE : S_FRD;
            end
            S_FDONE:
            begin
                cmd.load_ir = 1'b1;
                state_next  = S_RX;
            end
            S_RX:
            begin
                cmd.rf_rsel = RS_X;
                state_next  = S_RY;
            end
            S_RY:
            begin
                cmd.rf_rsel = RS_Y;
                cmd.cap     = CAP_A;
                state_next  = S_RZ;
            end
            S_RZ:
            begin
                cmd.rf_rsel = RS_Z;
                cmd.cap     = CAP_B;
                state_next  = S_DEC;
            end
            S_DEC:
            begin
                cmd.cap    = CAP_C;
                state_next = S_OPS;
            end
            S_OPS:
            begin
                cmd.k_clr = 1'b1;
                if (st.opcode == OP_HLT)
                begin
                    cmd.set_halt = 1'b1;
                    state_next   = S_PEEK;
                end
                else if (st.opcode == OP_NOP)
                begin
                    cmd.pc_adv = 1'b1;
                    state_next = S_PEEK;
                end
                else if (st.opcode == OP_CMP)
                begin
                    cmd.set_flags = 1'b1;
                    cmd.pc_adv    = 1'b1;
                    state_next    = S_PEEK;
                end
                else if (st.opcode == OP_UDIV || st.opcode == OP_UDIVI)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = (st.opcode == OP_UDIV) ? DS_RR : DS_RI;
                    state_next    = S_UDIV;
                end
                else if (st.opcode inside {OP_LDBO, OP_STBO, OP_LD, OP_ST})
                begin
                    cmd.div_src        = DS_ADDR;
                    cmd.base_from_addr = 1'b1;
                    state_next         = is_store ? S_MWR : S_LRD;
                end
                else if (st.opcode inside {[OP_JE:OP_JMP]})
                begin
                    cmd.pc_jump = st.jump_taken;
                    state_next  = S_PEEK;
                end
                else if (st.opcode == OP_RSV)
                begin
                    state_next = S_PEEK;
                end
                else
                begin
                    state_next = S_ALU;
                end
            end
            S_ALU:
            begin
                cmd.alu_exec = 1'b1;
                state_next   = S_WB;
            end
            S_WB:
            begin
                cmd.rf_wr  = 1'b1;
                cmd.wsrc   = WS_RES;
                cmd.pc_adv = 1'b1;
                state_next = S_PEEK;
            end
            S_UDIV:
            begin
                if (!st.div_busy)
                begin
                    cmd.rf_wr  = 1'b1;
                    cmd.wsrc   = WS_QUOT;
                    cmd.pc_adv = 1'b1;
                    state_next = S_PEEK;
                end
            end
            S_MWR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.k_inc  = 1'b1;
                if (st.k_last)
                begin
                    cmd.pc_adv = st.kind;
                    state_next = S_PEEK;
                end
            end
            S_LRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_LCAP;
            end
            S_LCAP:
            begin
                cmd.shift_in = 1'b1;
                cmd.k_inc    = 1'b1;
                state_next   = st.k_last ? S_LWB : S_LRD;
            end
            S_LWB:
            begin
                cmd.rf_wr  = 1'b1;
                cmd.wsrc   = WS_BUF;
                cmd.pc_adv = 1'b1;
                state_next = S_PEEK;
            end
            S_PEEK:
            begin
                cmd.rf_rsel = RS_PEEK;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                cmd.rf_rsel = RS_PEEK;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

    `SCIS_ASSERT(a_accept_busy, start && !busy |=> busy)
    `SCIS_ASSERT(a_done_then_idle, done |=> !busy)
    `SCIS_ASSERT(a_div_runs, cmd.div_start |=> st.div_busy)
    `SCIS_ASSERT(a_div_free, cmd.div_start |-> !st.div_busy)
    `SCIS_ASSERT_NEVER(a_idle_quiet, !busy && (cmd.mem_wr || cmd.rf_wr || cmd.pc_adv))
endmodule

>>> rtl/small_cpu_instruction_step.sv
// Top level of the small CPU instruction step block: controller plus datapath.
// Depends on scis_pkg, scis_ctrl, scis_dp (which holds scis_div).
//
//  channel  | ports               | handshake
//  ---------+---------------------+-------------------------------------
//  item     | start, busy, item   | beat taken when start & !busy
//  result   | done, result        | beat valid for one cycle on done
//
// A load beat writes four memory bytes. For a step beat the fetch reads four
// memory bytes, a data load reads four more, and udiv waits on the iterative
// divider. MEM_BYTES should be a power of two; the block does not enforce it.
// Addresses wrap by subtracting MEM_BYTES. The block returns to idle after
// each result. After reset a clearing pass zeroes memory and registers with
// busy high. The receiver cannot stall; each result shows for one cycle.
module small_cpu_instruction_step #(
    parameter int MEM_BYTES = scis_pkg::MEM_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  scis_pkg::in_t  item,
    output logic           done,
    output scis_pkg::out_t result
);
    import scis_pkg::*;

    cmd_t  cmd;
    stat_t st;

    scis_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    scis_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .st     (st),
        .result (result)
    );
endmodule
